// ===== rtl/fqrc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and helper functions of the frame QP rate controller.
// No dependencies; every other file but fqrc_div imports this package.
package fqrc_pkg;

	localparam logic [1:0] OP_PLAN = 2'd0;
	localparam logic [1:0] OP_DONE = 2'd1;
	localparam logic [1:0] OP_SET  = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [1:0] CFG_INITIAL_BITRATE = 2'd0;
	localparam logic [1:0] CFG_FRAME_RATE      = 2'd1;
	localparam logic [1:0] CFG_SOFT_RC_ENABLE  = 2'd2;

	localparam int QP_LO        = 16;
	localparam int QP_HI        = 45;
	localparam int KEY_QP_DELTA = 2;
	localparam int KEY_QP_JUMP  = 6;
	localparam int EMA_LIM      = 8388607;

	localparam logic [31:0] MIN_BITRATE  = 32'd100000;
	localparam logic [31:0] KEY_MIN_RATE = 32'd32;
	localparam logic [31:0] US_PER_SEC   = 32'd1000000;
	localparam logic [22:0] BITS_X_US    = 23'd8000000;
	localparam logic [7:0]  DEFAULT_FPS  = 8'd60;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_LATCH,
		CMD_LOG_A,
		CMD_LOG_B,
		CMD_SAVE_LB,
		CMD_DIV_FUS,
		CMD_SAVE_FUS,
		CMD_ELAP,
		CMD_WORK,
		CMD_DIV_EMA,
		CMD_SAVE_EMA,
		CMD_LOAD_EMA,
		CMD_DIV_Q_DIFF,
		CMD_DIV_Q_EMA,
		CMD_SAVE_Q,
		CMD_COMMIT
	} dp_cmd_t;

	typedef struct packed {
		logic       log_done;
		logic       div_done;
		logic [1:0] op;
		logic       is_key;
		logic       plan_pred;
		logic       done_skip;
		logic       work_big;
		logic       ema_valid;
		logic       set_adapt;
		logic       out_block;
	} dp_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_WFUS,
		S_ELAP,
		S_WORK,
		S_CHKW,
		S_WLA,
		S_WLB,
		S_BRANCH,
		S_WEMA,
		S_QEMA,
		S_WQ,
		S_FINISH
	} ctrl_state_t;

	typedef enum logic [1:0] {
		LG_IDLE,
		LG_NORM,
		LG_MUL,
		LG_SQ
	} log_state_t;

	// log2(9) - 3 in fixed point, i.e. log2(1.125); evaluated at elaboration
	function automatic logic [63:0] log_step(input int frac);
		logic [63:0] m;
		logic [63:0] r;
		begin
			m = 64'h9000_0000;
			r = 64'd3;
			for (int i = 0; i < frac; i++) begin
				m = (m * m) >> 31;
				r = r << 1;
				if (m >= 64'h1_0000_0000) begin
					r = r | 64'd1;
					m = m >> 1;
				end
			end
			return r - (64'd3 << frac);
		end
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [31:0] v,
		input logic signed [31:0] lo, input logic signed [31:0] hi);
		begin
			if (v < lo) return lo;
			if (v > hi) return hi;
			return v;
		end
	endfunction

	function automatic logic [5:0] sat_qp(input logic signed [31:0] v);
		logic signed [31:0] c;
		begin
			c = clamp32(v, 32'(QP_LO), 32'(QP_HI));
			return c[5:0];
		end
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
		logic signed [31:0] c;
		begin
			c = clamp32(v, -32'(EMA_LIM) - 32'sd1, 32'(EMA_LIM));
			return c[23:0];
		end
	endfunction

endpackage

// ===== rtl/fqrc_div.sv =====
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing.
module fqrc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [32:0] sh;
	logic [32:0] diff;
	logic        fits;

	assign sh   = {rem_q, quo_q[31]};
	assign diff = sh - {1'b0, dvs_q};
	assign fits = (sh >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[31:0] : sh[31:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ===== rtl/fqrc_log2.sv =====
`timescale 1ns / 1ps
// Sequential fixed-point log2: leading-one search one bit a cycle, then one
// squaring per fraction bit. Depends on fqrc_pkg.
module fqrc_log2 #(
	parameter int FRAC = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [63:0]       x,
	output logic              done,
	output logic [FRAC+5:0]   result
);
	import fqrc_pkg::*;

	localparam int RW = FRAC + 6;
	localparam int CW = $clog2(FRAC);

	log_state_t     state_q;
	logic           done_q;
	logic [63:0]    xs_q;
	logic [5:0]     n_q;
	logic [31:0]    m_q;
	logic [63:0]    sq_q;
	logic [RW-1:0]  r_q;
	logic [CW-1:0]  cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LG_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				LG_IDLE: begin
					if (start) begin
						if (x == 64'd0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= LG_NORM;
						end
					end
				end
				LG_NORM: begin
					if (xs_q[63]) begin
						cnt_q   <= '0;
						state_q <= LG_MUL;
					end
				end
				LG_MUL: state_q <= LG_SQ;
				LG_SQ: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(FRAC - 1)) begin
						done_q  <= 1'b1;
						state_q <= LG_IDLE;
					end else begin
						state_q <= LG_MUL;
					end
				end
				default: state_q <= LG_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			LG_IDLE: begin
				if (start) begin
					xs_q <= x;
					n_q  <= 6'd63;
					r_q  <= '0;
				end
			end
			LG_NORM: begin
				if (xs_q[63]) begin
					m_q <= xs_q[63:32];
					r_q <= RW'(n_q);
				end else begin
					xs_q <= {xs_q[62:0], 1'b0};
					n_q  <= n_q - 6'd1;
				end
			end
			LG_MUL: sq_q <= 64'(m_q) * 64'(m_q);
			LG_SQ: begin
				if (sq_q[63]) begin
					r_q <= {r_q[RW-2:0], 1'b1};
					m_q <= sq_q[63:32];
				end else begin
					r_q <= {r_q[RW-2:0], 1'b0};
					m_q <= sq_q[62:31];
				end
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = r_q;
endmodule

// ===== rtl/fqrc_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: rate-control state, item registers, log and divide units, result
// register. Depends on fqrc_pkg, fqrc_log2 and fqrc_div.
module fqrc_datapath #(
	parameter int INIT_QP       = 26,
	parameter int LOG_FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fqrc_pkg::dp_cmd_t     cmd,
	output fqrc_pkg::dp_status_t  status,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	input  logic [1:0]            op,
	input  logic                  is_key,
	input  logic [23:0]           coded_bytes,
	input  logic [63:0]           now_us,
	input  logic [31:0]           new_bitrate,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [5:0]            frame_qp,
	output logic                  accepted
);
	import fqrc_pkg::*;

	localparam int RW = LOG_FRAC_BITS + 6;
	localparam logic [31:0] K_STEP = 32'(log_step(LOG_FRAC_BITS));
	// doubled divisors of the two rounded constant divisions and their reciprocals
	localparam logic [31:0] D_QK   = {K_STEP[30:0], 1'b0};
	localparam logic [31:0] R_QK   = 32'(64'h1_0000_0000 / 64'(D_QK));
	localparam logic [31:0] R_EMA  = 32'(64'h1_0000_0000 / 64'd30);

	// rate-control state
	logic [5:0]         cur_qp_q;
	logic signed [23:0] ema_q;
	logic               ema_valid_q;
	logic [5:0]         kqs_q;
	logic [23:0]        kbs_q;
	logic [63:0]        last_q;
	logic [31:0]        cur_br_q;
	logic [5:0]         planned_q;
	logic [7:0]         fps_q;
	logic               en_q;

	// item and scratch
	logic [1:0]         op_q;
	logic               key_q;
	logic [23:0]        bytes_q;
	logic [63:0]        now_q;
	logic [31:0]        nb_q;
	logic [19:0]        fus_q;
	logic [21:0]        elap_q;
	logic [53:0]        work_q;
	logic [46:0]        prod_q;
	logic signed [RW:0] diff_q;
	logic               neg_q;
	logic signed [31:0] q_q;
	logic [RW-1:0]      log_res_a_q;

	logic               out_valid_q;
	logic [5:0]         frame_qp_q;
	logic               accepted_q;

	// units
	logic               log_start;
	logic [63:0]        log_x;
	logic               log_done;
	logic [RW-1:0]      log_res;
	logic               div_start;
	logic               fus_start;
	logic [31:0]        div_dividend;
	logic [31:0]        div_divisor;
	logic               div_done;
	logic [31:0]        div_quo;

	// constant-divisor unit: reciprocal estimate, then one correction step
	logic [31:0]        cd_x;
	logic [31:0]        cd_d;
	logic [31:0]        cd_recip;
	logic [63:0]        cd_prod_s1;
	logic [31:0]        cd_x_s1;
	logic [31:0]        cd_d_s1;
	logic               cd_v_s1;
	logic [31:0]        cd_qe_s2;
	logic [31:0]        cd_qd_s2;
	logic [31:0]        cd_x_s2;
	logic [31:0]        cd_d_s2;
	logic               cd_v_s2;
	logic [31:0]        cd_rem;
	logic [31:0]        cd_quo_q;
	logic               cd_done_q;

	fqrc_log2 #(.FRAC(LOG_FRAC_BITS)) u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.x      (log_x),
		.done   (log_done),
		.result (log_res)
	);

	// frame period only: 1000000 / fps
	fqrc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (fus_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	logic [63:0] src_key, src_cur, src_new, src_b8m, src_work;
	assign src_key  = {35'd0, kbs_q, 5'd0};
	assign src_cur  = {32'd0, cur_br_q};
	assign src_new  = {32'd0, nb_q};
	assign src_b8m  = {17'd0, prod_q};
	assign src_work = {10'd0, work_q};

	logic signed [31:0] diff32, lg32, ema32, a_ema, div_a, div_mag;
	logic signed [31:0] q_signed;
	logic [31:0]        div_b;
	logic [7:0]         fps_eff;

	assign diff32   = 32'(diff_q);
	assign lg32     = 32'(sat24(diff32));
	assign ema32    = 32'(ema_q);
	assign a_ema    = ema32 * 32'sd14 + lg32;
	assign fps_eff  = (fps_q == 8'd0) ? DEFAULT_FPS : fps_q;
	assign q_signed = neg_q ? -$signed(cd_quo_q) : $signed(cd_quo_q);

	assign fus_start    = (cmd == CMD_DIV_FUS);
	assign div_dividend = US_PER_SEC;
	assign div_divisor  = {24'd0, fps_eff};

	always_comb begin
		log_start    = 1'b0;
		log_x        = src_cur;
		div_start    = 1'b0;
		div_a        = diff32;
		div_b        = K_STEP;
		cd_recip     = R_QK;
		unique case (cmd)
			CMD_LOG_A: begin
				log_start = 1'b1;
				priority case (op_q)
					OP_PLAN: log_x = src_key;
					OP_DONE: log_x = src_b8m;
					default: log_x = src_cur;
				endcase
			end
			CMD_LOG_B: begin
				log_start = 1'b1;
				priority case (op_q)
					OP_PLAN: log_x = src_cur;
					OP_DONE: log_x = src_work;
					default: log_x = src_new;
				endcase
			end
			CMD_DIV_EMA: begin
				div_start = 1'b1;
				div_a     = a_ema;
				div_b     = 32'd15;
				cd_recip  = R_EMA;
			end
			CMD_DIV_Q_DIFF: div_start = 1'b1;
			CMD_DIV_Q_EMA: begin
				div_start = 1'b1;
				div_a     = ema32;
			end
			default: ;
		endcase
		div_mag = (div_a < 0) ? -div_a : div_a;
		// round half away from zero: (2|a| + b) / 2b
		cd_x = {div_mag[30:0], 1'b0} + div_b;
		cd_d = {div_b[30:0], 1'b0};
	end

	// the estimate is low by at most one, since the dividend stays below 2^32
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_v_s1   <= 1'b0;
			cd_v_s2   <= 1'b0;
			cd_done_q <= 1'b0;
		end else begin
			cd_v_s1   <= div_start;
			cd_v_s2   <= cd_v_s1;
			cd_done_q <= cd_v_s2;
		end
	end

	assign cd_rem = cd_x_s2 - cd_qd_s2;

	always_ff @(posedge clk) begin
		cd_prod_s1 <= 64'(cd_x) * 64'(cd_recip);
		cd_x_s1    <= cd_x;
		cd_d_s1    <= cd_d;
		cd_qe_s2   <= cd_prod_s1[63:32];
		cd_qd_s2   <= cd_prod_s1[63:32] * cd_d_s1;
		cd_x_s2    <= cd_x_s1;
		cd_d_s2    <= cd_d_s1;
		if (cd_v_s2) cd_quo_q <= cd_qe_s2 + {31'd0, (cd_rem >= cd_d_s2)};
	end

	// final update of the item
	logic signed [31:0] cur32, kqs32, base, pred_c, key_q1, key_q2;
	logic [5:0]         plan_qp, next_cur;
	logic               set_ignore, plan_pred, done_skip, work_big, set_adapt;

	assign cur32      = {26'd0, cur_qp_q};
	assign kqs32      = {26'd0, kqs_q};
	assign base       = cur32 + 32'(KEY_QP_DELTA);
	assign pred_c     = clamp32(kqs32 + q_q, kqs32 - 32'(KEY_QP_JUMP),
		kqs32 + 32'(KEY_QP_JUMP));
	assign key_q1     = plan_pred ? pred_c : base;
	assign key_q2     = (key_q1 < base) ? base : key_q1;
	assign plan_qp    = key_q ? sat_qp(key_q2) : sat_qp(cur32);
	assign set_ignore = (nb_q < MIN_BITRATE);
	assign plan_pred  = (kbs_q != 24'd0) && (cur_br_q > KEY_MIN_RATE);
	assign done_skip  = !en_q || (bytes_q == 24'd0);
	assign work_big   = (work_q > 54'(BITS_X_US));
	assign set_adapt  = !set_ignore && en_q && (cur_br_q != 32'd0) && (nb_q != cur_br_q);

	always_comb begin
		next_cur = cur_qp_q;
		if (op_q == OP_DONE && !done_skip && !key_q && work_big) begin
			next_cur = sat_qp(cur32 + clamp32(q_q, -32'sd1, 32'sd1));
		end else if (op_q == OP_SET && set_adapt) begin
			next_cur = sat_qp(cur32 + q_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_qp_q    <= 6'(INIT_QP);
			ema_q       <= '0;
			ema_valid_q <= 1'b0;
			kqs_q       <= '0;
			kbs_q       <= '0;
			last_q      <= '0;
			cur_br_q    <= '0;
			planned_q   <= '0;
			fps_q       <= DEFAULT_FPS;
			en_q        <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_INITIAL_BITRATE: cur_br_q <= cfg_data;
					CFG_FRAME_RATE:      fps_q    <= cfg_data[7:0];
					CFG_SOFT_RC_ENABLE:  en_q     <= cfg_data[0];
					default: ;
				endcase
			end
			unique case (cmd)
				CMD_ELAP: last_q <= now_q;
				CMD_LOAD_EMA: begin
					ema_q       <= sat24(diff32);
					ema_valid_q <= 1'b1;
				end
				CMD_SAVE_EMA: begin
					ema_q       <= sat24(q_signed);
					ema_valid_q <= 1'b1;
				end
				CMD_COMMIT: begin
					out_valid_q <= 1'b1;
					cur_qp_q    <= next_cur;
					unique case (op_q)
						OP_PLAN: planned_q <= plan_qp;
						OP_DONE: begin
							if (!done_skip && key_q) begin
								kqs_q <= planned_q;
								kbs_q <= bytes_q;
							end
						end
						OP_SET: begin
							if (!set_ignore) cur_br_q <= nb_q;
							if (set_adapt) begin
								ema_q       <= '0;
								ema_valid_q <= 1'b0;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_LATCH: begin
				op_q    <= op;
				key_q   <= is_key;
				bytes_q <= coded_bytes;
				now_q   <= now_us;
				nb_q    <= new_bitrate;
			end
			CMD_SAVE_FUS: fus_q <= div_quo[19:0];
			CMD_ELAP: begin
				if (last_q == 64'd0) begin
					elap_q <= {2'd0, fus_q};
				end else if ((now_q - last_q) > 64'({fus_q, 2'b00})) begin
					elap_q <= {fus_q, 2'b00};
				end else begin
					elap_q <= 22'(now_q - last_q);
				end
			end
			CMD_WORK: begin
				work_q <= 54'(cur_br_q) * 54'(elap_q);
				prod_q <= 47'(bytes_q) * 47'(BITS_X_US);
			end
			CMD_SAVE_LB: diff_q <= $signed({1'b0, log_res_a_q}) - $signed({1'b0, log_res});
			CMD_SAVE_Q: q_q <= q_signed;
			CMD_COMMIT: begin
				frame_qp_q <= (op_q == OP_PLAN) ? plan_qp : sat_qp({26'd0, next_cur});
				accepted_q <= !((op_q == OP_NONE) || (op_q == OP_SET && set_ignore));
			end
			default: ;
		endcase
		if (div_start) neg_q <= (div_a < 0);
		if (cmd == CMD_LOG_B) log_res_a_q <= log_res;
	end

	assign status.log_done  = log_done;
	assign status.div_done  = div_done | cd_done_q;
	assign status.op        = op_q;
	assign status.is_key    = key_q;
	assign status.plan_pred = plan_pred;
	assign status.done_skip = done_skip;
	assign status.work_big  = work_big;
	assign status.ema_valid = ema_valid_q;
	assign status.set_adapt = set_adapt;
	assign status.out_block = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign frame_qp  = frame_qp_q;
	assign accepted  = accepted_q;
endmodule

// ===== rtl/fqrc_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences one item through the datapath by command codes.
// Depends on fqrc_pkg.
module fqrc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  fqrc_pkg::dp_status_t  status,
	output fqrc_pkg::dp_cmd_t     cmd
);
	import fqrc_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = CMD_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd     = CMD_LATCH;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (status.op)
					OP_PLAN: begin
						if (status.is_key && status.plan_pred) begin
							cmd     = CMD_LOG_A;
							state_d = S_WLA;
						end else begin
							state_d = S_FINISH;
						end
					end
					OP_DONE: begin
						if (status.done_skip) begin
							state_d = S_FINISH;
						end else begin
							cmd     = CMD_DIV_FUS;
							state_d = S_WFUS;
						end
					end
					OP_SET: begin
						if (status.set_adapt) begin
							cmd     = CMD_LOG_A;
							state_d = S_WLA;
						end else begin
							state_d = S_FINISH;
						end
					end
					default: state_d = S_FINISH;
				endcase
			end
			S_WFUS: begin
				if (status.div_done) begin
					cmd     = CMD_SAVE_FUS;
					state_d = S_ELAP;
				end
			end
			S_ELAP: begin
				cmd     = CMD_ELAP;
				state_d = status.is_key ? S_FINISH : S_WORK;
			end
			S_WORK: begin
				cmd     = CMD_WORK;
				state_d = S_CHKW;
			end
			S_CHKW: begin
				if (status.work_big) begin
					cmd     = CMD_LOG_A;
					state_d = S_WLA;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_WLA: begin
				if (status.log_done) begin
					cmd     = CMD_LOG_B;
					state_d = S_WLB;
				end
			end
			S_WLB: begin
				if (status.log_done) begin
					cmd     = CMD_SAVE_LB;
					state_d = S_BRANCH;
				end
			end
			S_BRANCH: begin
				if (status.op == OP_DONE) begin
					if (status.ema_valid) begin
						cmd     = CMD_DIV_EMA;
						state_d = S_WEMA;
					end else begin
						cmd     = CMD_LOAD_EMA;
						state_d = S_QEMA;
					end
				end else begin
					cmd     = CMD_DIV_Q_DIFF;
					state_d = S_WQ;
				end
			end
			S_WEMA: begin
				if (status.div_done) begin
					cmd     = CMD_SAVE_EMA;
					state_d = S_QEMA;
				end
			end
			S_QEMA: begin
				cmd     = CMD_DIV_Q_EMA;
				state_d = S_WQ;
			end
			S_WQ: begin
				if (status.div_done) begin
					cmd     = CMD_SAVE_Q;
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!status.out_block) begin
					cmd     = CMD_COMMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// ===== rtl/frame_qp_rate_controller.sv =====
`timescale 1ns / 1ps
// Frame-level QP rate controller: top level (fqrc_ctrl + fqrc_datapath).
// A plain plan or an item that changes nothing goes straight to the commit; a key done and a
// done below the work floor stop after the elapsed time or the work product; a key plan or an
// adapting set bitrate, and any other done, run the two logarithms and the rounded divisions;
// a result still waiting holds the commit. One item at a time.
// Reset (arst_n low, asynchronous): state to its initial values, no result held.
module frame_qp_rate_controller #(
	parameter int INIT_QP       = 26,
	parameter int LOG_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input beat
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic        is_key,
	input  logic [23:0] coded_bytes,
	input  logic [63:0] now_us,
	input  logic [31:0] new_bitrate,
	// result beat
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  frame_qp,
	output logic        accepted
);
	import fqrc_pkg::*;

	// The controller walks each beat through its steps: latch the item,
	// compute the frame period, elapsed time and work product for a done
	// item, run the two logarithms and the rounded divisions, then commit.
	// The commit waits only while the result register still holds an
	// untaken beat, so a finished result never blocks the next item's work.
	dp_cmd_t    cmd;
	dp_status_t status;

	fqrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Hold all rate-control state and the result register in the datapath.
	fqrc_datapath #(
		.INIT_QP       (INIT_QP),
		.LOG_FRAC_BITS (LOG_FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.op          (op),
		.is_key      (is_key),
		.coded_bytes (coded_bytes),
		.now_us      (now_us),
		.new_bitrate (new_bitrate),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.frame_qp    (frame_qp),
		.accepted    (accepted)
	);
endmodule
